// ===== hdl/qdmp_pkg.sv =====
// ----------------------------------------------------------------------------
// qdmp_pkg
// Shared types and constants for the QR data module placement block.
// ----------------------------------------------------------------------------
`default_nettype none

package qdmp_pkg;

   localparam int MAX_VERSION      = 40;
   localparam int ALIGN_SLOTS      = 7;
   localparam int COORD_W          = 8;
   localparam int VERSION_W        = 6;
   localparam int SIZE_BASE        = 17;
   localparam int FINDER_SPAN      = 8;
   localparam int TIMING_LINE      = 6;
   localparam int VERSION_INFO_MIN = 7;
   localparam int INFO_NEAR        = 9;
   localparam int INFO_FAR         = 11;
   localparam int INFO_DEPTH       = 5;
   localparam int ALIGN_EDGE       = 10;
   localparam int ALIGN_HALF       = 2;
   localparam int SKIP_COL         = 5;
   localparam int SKIP_TO_COL      = 4;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

   // csr register indexes
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_VERSION     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALIGN_FIRST = 3'd1;

   typedef logic [COORD_W-1:0] coord_type;
   typedef coord_type [ALIGN_SLOTS-1:0] align_set_type;

   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_SEEK,
      WALK_SEEK_NEXT
   } walk_state_type;

   typedef struct packed {
      logic first_bit;
      logic data_bit;
   } bit_item_type;

   typedef struct packed {
      logic         valid;
      bit_item_type item;
   } queue_head_type;

   typedef struct packed {
      coord_type size;
      logic      info_on;
   } symbol_type;

endpackage

`default_nettype wire

// ===== hdl/qdmp_queue.sv =====
// ----------------------------------------------------------------------------
// qdmp_queue
// Front end: accepts requests and holds them in a short queue, split into
// restart flag and data bit, until the walker takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module qdmp_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output      logic                    req_tready,
   input  wire logic [7:0]              req_tdata,   // [0] data_bit
   input  wire logic [0:0]              req_tuser,   // [0] first_bit
   input  wire logic                    pop,
   output      qdmp_pkg::queue_head_type head
);
   import qdmp_pkg::*;

   bit_item_type             slot_ff [QUEUE_DEPTH];
   bit_item_type             slot_in [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     push;
   logic                     take;

   assign req_tready = (count_ff < QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];
   assign take       = pop && head.valid;

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff].first_bit = req_tuser[0];
         slot_in[wr_ptr_ff].data_bit  = req_tdata[0];
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/qdmp_resv.sv =====
// ----------------------------------------------------------------------------
// qdmp_resv
// Function-pattern map: flags a module inside the symbol as reserved
// (finders, separators, timing lines, version info, alignment patterns).
// ----------------------------------------------------------------------------
`default_nettype none

module qdmp_resv (
   input  wire qdmp_pkg::symbol_type    sym,
   input  wire qdmp_pkg::align_set_type align,
   input  wire qdmp_pkg::coord_type     col,
   input  wire qdmp_pkg::coord_type     row,
   output      logic                    reserved
);
   import qdmp_pkg::*;

   logic [ALIGN_SLOTS-1:0] used, lo, hi, col_hit, row_hit;
   logic                   finder, timing, info, pattern;
   logic [COORD_W:0]       col_x, row_x, pos_x;

   always_comb begin
      col_x = {1'b0, col};
      row_x = {1'b0, row};
      for (int i = 0; i < ALIGN_SLOTS; i++) begin
         pos_x      = {1'b0, align[i]};
         used[i]    = (align[i] != '0);
         lo[i]      = (align[i] < COORD_W'(ALIGN_EDGE));
         hi[i]      = (align[i] > sym.size - COORD_W'(ALIGN_EDGE));
         col_hit[i] = used[i] && (col_x + (COORD_W+1)'(ALIGN_HALF) >= pos_x)
                      && (col_x <= pos_x + (COORD_W+1)'(ALIGN_HALF));
         row_hit[i] = used[i] && (row_x + (COORD_W+1)'(ALIGN_HALF) >= pos_x)
                      && (row_x <= pos_x + (COORD_W+1)'(ALIGN_HALF));
      end
      pattern = 1'b0;
      for (int i = 0; i < ALIGN_SLOTS; i++) begin
         for (int j = 0; j < ALIGN_SLOTS; j++) begin
            // centres on a finder corner are left out
            if (col_hit[i] && row_hit[j] && !(lo[i] && lo[j]) && !(hi[i] && lo[j])
                && !(lo[i] && hi[j])) begin
               pattern = 1'b1;
            end
         end
      end
      finder = ((col <= COORD_W'(FINDER_SPAN)) && (row <= COORD_W'(FINDER_SPAN)))
            || ((col >= sym.size - COORD_W'(FINDER_SPAN)) && (row <= COORD_W'(FINDER_SPAN)))
            || ((col <= COORD_W'(FINDER_SPAN)) && (row >= sym.size - COORD_W'(FINDER_SPAN)));
      timing = (row == COORD_W'(TIMING_LINE)) || (col == COORD_W'(TIMING_LINE));
      info   = sym.info_on &&
               (((col >= sym.size - COORD_W'(INFO_FAR)) && (col <= sym.size - COORD_W'(INFO_NEAR))
                 && (row <= COORD_W'(INFO_DEPTH)))
             || ((col <= COORD_W'(INFO_DEPTH)) && (row >= sym.size - COORD_W'(INFO_FAR))
                 && (row <= sym.size - COORD_W'(INFO_NEAR))));
      reserved = finder || timing || info || pattern;
   end

endmodule

`default_nettype wire

// ===== hdl/qdmp_walker.sv =====
// ----------------------------------------------------------------------------
// qdmp_walker
// Back end: zigzag walk over the symbol, one candidate module per cycle while
// seeking, with the result register toward the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module qdmp_walker (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire qdmp_pkg::symbol_type    sym,
   input  wire qdmp_pkg::align_set_type align,
   input  wire qdmp_pkg::queue_head_type head,
   output      logic                    pop,
   output      logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   output      logic [23:0]             rsp_tdata,   // [7:0] module_col, [15:8] module_row,
                                                     // [16] dark
   output      logic                    rsp_tlast,   // last_free
   output      logic [0:0]              rsp_tuser    // [0] no_room
);
   import qdmp_pkg::*;

   walk_state_type state_ff, state_in;
   coord_type      walk_col_ff, walk_col_in;
   coord_type      walk_row_ff, walk_row_in;
   logic           going_up_ff, going_up_in;
   logic           right_half_ff, right_half_in;
   logic           walk_done_ff, walk_done_in;
   logic           dark_ff, dark_in;
   coord_type      hit_col_ff, hit_col_in;
   coord_type      hit_row_ff, hit_row_in;
   logic           rsp_valid_ff, rsp_valid_in;
   coord_type      rsp_col_ff, rsp_col_in;
   coord_type      rsp_row_ff, rsp_row_in;
   logic           rsp_dark_ff, rsp_dark_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_none_ff, rsp_none_in;

   logic [COORD_W:0] cand_col;
   logic             in_range, reserved, cand_free;
   logic             out_free, finish, load_rsp, step;
   coord_type        adv_col, adv_row;
   logic             adv_up, adv_right, adv_done;
   logic             turned;
   logic [COORD_W:0] row_nx;

   assign cand_col = {1'b0, walk_col_ff} + (COORD_W+1)'(right_half_ff);
   assign in_range = (cand_col < {1'b0, sym.size}) && (walk_row_ff < sym.size);
   assign cand_free = in_range && !reserved;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   qdmp_resv u_resv (
      .sym      (sym),
      .align    (align),
      .col      (cand_col[COORD_W-1:0]),
      .row      (walk_row_ff),
      .reserved (reserved)
   );

   // one step of the zigzag; a step past the top or bottom edge turns the walk
   always_comb begin
      adv_col   = walk_col_ff;
      adv_row   = walk_row_ff;
      adv_up    = going_up_ff;
      adv_done  = walk_done_ff;
      adv_right = !right_half_ff;
      turned    = 1'b0;
      row_nx    = going_up_ff ? ({1'b0, walk_row_ff} - 1'b1) : ({1'b0, walk_row_ff} + 1'b1);
      if (!right_half_ff) begin
         if (going_up_ff && (walk_row_ff == '0)) begin
            turned  = 1'b1;
            adv_up  = 1'b0;
            adv_col = walk_col_ff - COORD_W'(2);
            adv_row = '0;
         end else if (row_nx >= {1'b0, sym.size}) begin
            turned  = 1'b1;
            adv_up  = 1'b1;
            adv_col = walk_col_ff - COORD_W'(2);
            adv_row = sym.size - 1'b1;
         end else begin
            adv_row = row_nx[COORD_W-1:0];
         end
         if (adv_col == COORD_W'(SKIP_COL)) begin
            adv_col = COORD_W'(SKIP_TO_COL);
         end
         if (turned && (walk_col_ff < COORD_W'(2))) begin
            adv_done = 1'b1;
            adv_col  = '0;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      walk_col_in   = walk_col_ff;
      walk_row_in   = walk_row_ff;
      going_up_in   = going_up_ff;
      right_half_in = right_half_ff;
      walk_done_in  = walk_done_ff;
      dark_in       = dark_ff;
      hit_col_in    = hit_col_ff;
      hit_row_in    = hit_row_ff;
      finish        = 1'b0;
      step          = 1'b0;
      pop           = 1'b0;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_dark_in   = rsp_dark_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_none_in   = rsp_none_ff;

      unique case (state_ff)
         WALK_IDLE: begin
            pop = head.valid;
         end
         WALK_SEEK: begin
            if (walk_done_ff) begin
               finish = 1'b1;
            end else if (cand_free) begin
               hit_col_in = cand_col[COORD_W-1:0];
               hit_row_in = walk_row_ff;
               step       = 1'b1;
               state_in   = WALK_SEEK_NEXT;
            end else begin
               step = 1'b1;
            end
         end
         WALK_SEEK_NEXT: begin
            if (walk_done_ff || cand_free) begin
               finish = 1'b1;
            end else begin
               step = 1'b1;
            end
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase

      if (step) begin
         walk_col_in   = adv_col;
         walk_row_in   = adv_row;
         going_up_in   = adv_up;
         right_half_in = adv_right;
         walk_done_in  = adv_done;
      end

      load_rsp = finish && out_free;
      if (load_rsp) begin
         if (state_ff == WALK_SEEK) begin
            rsp_col_in  = '0;
            rsp_row_in  = '0;
            rsp_dark_in = 1'b0;
            rsp_last_in = 1'b0;
            rsp_none_in = 1'b1;
         end else begin
            rsp_col_in  = hit_col_ff;
            rsp_row_in  = hit_row_ff;
            rsp_dark_in = dark_ff;
            rsp_last_in = walk_done_ff;
            rsp_none_in = 1'b0;
         end
         pop      = head.valid;
         state_in = WALK_IDLE;
      end

      if (pop) begin
         dark_in  = head.item.data_bit;
         state_in = WALK_SEEK;
         if (head.item.first_bit) begin
            walk_col_in   = sym.size - COORD_W'(2);
            walk_row_in   = sym.size - 1'b1;
            going_up_in   = 1'b1;
            right_half_in = 1'b1;
            walk_done_in  = 1'b0;
         end
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dark_ff     <= dark_in;
      hit_col_ff  <= hit_col_in;
      hit_row_ff  <= hit_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_dark_ff <= rsp_dark_in;
      rsp_last_ff <= rsp_last_in;
      rsp_none_ff <= rsp_none_in;
      if (reset) begin
         state_ff      <= WALK_IDLE;
         walk_col_ff   <= '0;
         walk_row_ff   <= '0;
         going_up_ff   <= 1'b1;
         right_half_ff <= 1'b1;
         walk_done_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_col_ff   <= walk_col_in;
         walk_row_ff   <= walk_row_in;
         going_up_ff   <= going_up_in;
         right_half_ff <= right_half_in;
         walk_done_ff  <= walk_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_dark_ff, rsp_row_ff, rsp_col_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_none_ff;

`ifndef SYNTH
   a_pop_has_item : assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("walker took from an empty queue");

   a_done_at_left : assert property (@(posedge clock) disable iff (reset)
      walk_done_ff |-> (walk_col_ff == '0))
      else $error("finished walk not parked at column zero");

   a_drop_is_blank : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_none_ff) |->
         (rsp_col_ff == '0 && rsp_row_ff == '0 && !rsp_dark_ff && !rsp_last_ff))
      else $error("dropped bit carries a position");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !load_rsp)
      else $error("result register overwritten while stalled");

   a_step_flips_half : assert property (@(posedge clock) disable iff (reset)
      (step && !pop) |=> (right_half_ff != $past(right_half_ff)))
      else $error("walk step did not alternate column half");
`endif

endmodule

`default_nettype wire

// ===== hdl/qr_data_module_placement.sv =====
// ----------------------------------------------------------------------------
// qr_data_module_placement
// Places serialized data bits on QR symbol modules along the standard
// two-column zigzag, passing over all function-pattern modules.
// ----------------------------------------------------------------------------
// A request passes through the queue, the walker's search for its module and
//   for the next free one, and the result register toward the response channel.
// The queue takes new requests during a walk; the walker pops the next as it
//   loads a result and tests one candidate module per cycle while seeking.
// Reset (synchronous): version 1, no alignment centres, walk at (0,0),
//   queue and response register empty.
`default_nettype none

module qr_data_module_placement (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [7:0]                    req_tdata,  // [0] data_bit
   input  wire logic [0:0]                    req_tuser,  // [0] first_bit
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [23:0]                   rsp_tdata,  // [7:0] module_col,
                                                          // [15:8] module_row, [16] dark
   output      logic                          rsp_tlast,  // last_free
   output      logic [0:0]                    rsp_tuser,  // [0] no_room
   input  wire logic                          csr_we,
   input  wire logic [qdmp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [qdmp_pkg::COORD_W-1:0]  csr_wdata
);
   import qdmp_pkg::*;

   logic [VERSION_W-1:0] version_ff, version_in;
   align_set_type        align_ff, align_in;
   logic [VERSION_W-1:0] ver_eff;
   symbol_type           sym;
   queue_head_type       head;
   logic                 pop;

   always_comb begin
      version_in = version_ff;
      align_in   = align_ff;
      if (csr_we) begin
         if (csr_addr == CSR_VERSION) begin
            version_in = csr_wdata[VERSION_W-1:0];
         end
         for (int i = 0; i < ALIGN_SLOTS; i++) begin
            if (csr_addr == CSR_ADDR_W'(int'(CSR_ALIGN_FIRST) + i)) begin
               align_in[i] = csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_W'(1);
         align_ff   <= '0;
      end else begin
         version_ff <= version_in;
         align_ff   <= align_in;
      end
   end

   always_comb begin
      if (version_ff == '0) begin
         ver_eff = VERSION_W'(1);
      end else if (version_ff > VERSION_W'(MAX_VERSION)) begin
         ver_eff = VERSION_W'(MAX_VERSION);
      end else begin
         ver_eff = version_ff;
      end
      sym.size    = {ver_eff, 2'b00} + COORD_W'(SIZE_BASE);
      sym.info_on = (ver_eff >= VERSION_W'(VERSION_INFO_MIN));
   end

   qdmp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pop        (pop),
      .head       (head)
   );

   qdmp_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .sym        (sym),
      .align      (align_ff),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_qr_data_module_placement.sv =====
// ----------------------------------------------------------------------------
// tb_qr_data_module_placement
// Self-checking bench for the QR data module placement block. A directed
// table covers the corner start, version clamping, an edge alignment pattern
// and a version change mid-walk. Random phases follow: whole symbol fills and
// short walks under random versions and alignment centres. Every response is
// checked against the table's expected values or an in-bench zigzag walk model.
// ----------------------------------------------------------------------------

module tb_qr_data_module_placement;
   import qdmp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3_000_000;

   typedef struct packed {
      logic [7:0] col;
      logic [7:0] row;
      logic       dark;
      logic       last_free;
      logic       no_room;
   } placement_type;

   typedef struct packed {
      bit                    is_csr;
      logic [CSR_ADDR_W-1:0] addr;
      logic [7:0]            wdata;
      bit                    first;
      bit                    data;
      bit                    typed;
      placement_type         want;
   } step_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [0] data_bit
   logic [0:0]            req_tuser;   // [0] first_bit
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;   // [7:0] module_col, [15:8] module_row, [16] dark
   logic                  rsp_tlast;   // last_free
   logic [0:0]            rsp_tuser;   // [0] no_room
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [COORD_W-1:0]    csr_wdata;

   qr_data_module_placement dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model state
   logic [5:0] pv_version;
   logic [7:0] pv_align [ALIGN_SLOTS];
   logic [7:0] wk_col;
   logic [7:0] wk_row;
   bit         wk_up;
   bit         wk_right;
   bit         wk_done;

   placement_type placements_due [$];
   step_row_type  plan [$];
   int            errors = 0;
   int            cycles = 0;
   int            hold = 0;
   bit            calm = 0;

   function automatic int side_modules();
      int v;
      v = int'(pv_version);
      if (v < 1) v = 1;
      if (v > MAX_VERSION) v = MAX_VERSION;
      return 4 * v + SIZE_BASE;
   endfunction

   function automatic bit module_taken(int c, int r, int sz);
      int v, x, y, dc, dr;
      v = (sz - SIZE_BASE) / 4;
      if (c <= 8 && r <= 8) return 1;
      if (c >= sz - 8 && r <= 8) return 1;
      if (c <= 8 && r >= sz - 8) return 1;
      if (r == TIMING_LINE || c == TIMING_LINE) return 1;
      if (v >= VERSION_INFO_MIN) begin
         if (c >= sz - 11 && c <= sz - 9 && r <= 5) return 1;
         if (c <= 5 && r >= sz - 11 && r <= sz - 9) return 1;
      end
      for (int i = 0; i < ALIGN_SLOTS; i++) begin
         x = int'(pv_align[i]);
         if (x == 0) continue;
         for (int j = 0; j < ALIGN_SLOTS; j++) begin
            y = int'(pv_align[j]);
            if (y == 0) continue;
            if (x < 10 && y < 10) continue;
            if (x > sz - 10 && y < 10) continue;
            if (x < 10 && y > sz - 10) continue;
            dc = c - x;
            dr = r - y;
            if (dc >= -2 && dc <= 2 && dr >= -2 && dr <= 2) return 1;
         end
      end
      return 0;
   endfunction

   function automatic bit on_free(int sz);
      int c, r;
      c = int'(wk_col) + (wk_right ? 1 : 0);
      r = int'(wk_row);
      if (c >= sz || r >= sz) return 0;
      return !module_taken(c, r, sz);
   endfunction

   function automatic void walk_advance(int sz);
      int c, r;
      c = int'(wk_col);
      r = int'(wk_row);
      if (!wk_right) begin
         r += wk_up ? -1 : 1;
         if (r >= sz) begin
            wk_up = 1;
            c -= 2;
            r = sz - 1;
         end else if (r < 0) begin
            wk_up = 0;
            c -= 2;
            r = 0;
         end
         if (c == SKIP_COL) c = SKIP_TO_COL;
      end
      wk_right = !wk_right;
      if (c < 0) begin
         wk_done = 1;
         c = 0;
      end
      wk_col = 8'(c);
      wk_row = 8'(r);
   endfunction

   function automatic void walk_seek(int sz);
      while (!wk_done && !on_free(sz)) walk_advance(sz);
   endfunction

   function automatic placement_type predict_placement(bit f, bit d);
      placement_type p;
      int sz;
      sz = side_modules();
      p = '0;
      if (f) begin
         wk_col = 8'(sz - 2);
         wk_row = 8'(sz - 1);
         wk_up = 1;
         wk_right = 1;
         wk_done = 0;
      end
      walk_seek(sz);
      if (wk_done) begin
         p.no_room = 1'b1;
         return p;
      end
      p.col = wk_col + (wk_right ? 8'd1 : 8'd0);
      p.row = wk_row;
      p.dark = d;
      walk_advance(sz);
      walk_seek(sz);
      p.last_free = wk_done;
      return p;
   endfunction

   function automatic void add_step(step_row_type s);
      plan = {plan, s};
   endfunction

   function automatic step_row_type req_row(bit f, bit d);
      step_row_type s;
      s = '0;
      s.first = f;
      s.data = d;
      return s;
   endfunction

   function automatic step_row_type typed_row(bit f, bit d, int c, int r, bit dk, bit lf,
                                              bit nr);
      step_row_type s;
      s = req_row(f, d);
      s.typed = 1;
      s.want = '{8'(c), 8'(r), dk, lf, nr};
      return s;
   endfunction

   function automatic step_row_type csr_row(logic [CSR_ADDR_W-1:0] a, int v);
      step_row_type s;
      s = '0;
      s.is_csr = 1;
      s.addr = a;
      s.wdata = 8'(v);
      return s;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic push_request(bit f, bit d, bit typed, placement_type want);
      placement_type got;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, d};
      req_tuser <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      got = predict_placement(f, d);
      placements_due = {placements_due, (typed ? want : got)};
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (placements_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_ADDR_W-1:0] a, logic [7:0] v);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= v;
      @(posedge clock);
      if (a == CSR_VERSION) pv_version = v[5:0];
      else pv_align[a - CSR_ALIGN_FIRST] = v;
   endtask

   task automatic random_config(bit full);
      int v, r, sz;
      logic [7:0] val;
      settle();
      r = $urandom_range(0, 9);
      if (full) v = $urandom_range(0, 1);
      else if (r < 6) v = $urandom_range(1, 10);
      else if (r < 8) v = $urandom_range(11, 40);
      else v = $urandom_range(0, 63);
      put_reg(CSR_VERSION, {2'($urandom_range(0, 3)), 6'(v)});
      sz = side_modules();
      for (int i = 0; i < ALIGN_SLOTS; i++) begin
         if ($urandom_range(0, 1)) val = 8'd0;
         else if ($urandom_range(0, 3) == 0) val = 8'($urandom_range(0, 255));
         else val = 8'($urandom_range(0, sz + 2));
         put_reg(CSR_ALIGN_FIRST + 3'(i), val);
      end
      csr_we <= 1'b0;
   endtask

   // response side back-pressure
   always @(posedge clock) begin
      if (hold > 0) begin
         hold = hold - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(15, 60);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      placement_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (placements_due.size() == 0) begin
            $error("response with no request pending");
            errors++;
         end else begin
            want = placements_due.pop_front();
            if (rsp_tdata[7:0] !== want.col) begin
               $error("module_col expected %0d actual %0d", want.col, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[15:8] !== want.row) begin
               $error("module_row expected %0d actual %0d", want.row, rsp_tdata[15:8]);
               errors++;
            end
            if (rsp_tdata[16] !== want.dark) begin
               $error("dark expected %0d actual %0d", want.dark, rsp_tdata[16]);
               errors++;
            end
            if (rsp_tlast !== want.last_free) begin
               $error("last_free expected %0d actual %0d", want.last_free, rsp_tlast);
               errors++;
            end
            if (rsp_tuser[0] !== want.no_room) begin
               $error("no_room expected %0d actual %0d", want.no_room, rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      bit in_csr, full, f;
      int n, k;
      step_row_type s;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;

      pv_version = 6'd1;
      foreach (pv_align[i]) pv_align[i] = 8'd0;
      wk_col = 8'd0;
      wk_row = 8'd0;
      wk_up = 1;
      wk_right = 1;
      wk_done = 0;

      // no restart after reset: nothing free at (0,0)
      add_step(typed_row(1'b0, 1'b1, 0, 0, 1'b0, 1'b0, 1'b1));
      add_step(typed_row(1'b1, 1'b1, 20, 20, 1'b1, 1'b0, 1'b0));
      add_step(req_row(1'b0, 1'b0));
      add_step(req_row(1'b0, 1'b1));
      add_step(req_row(1'b1, 1'b0));
      // version 0 clamps to 1
      add_step(csr_row(CSR_VERSION, 0));
      add_step(typed_row(1'b1, 1'b0, 20, 20, 1'b0, 1'b0, 1'b0));
      add_step(csr_row(CSR_VERSION, 40));
      add_step(typed_row(1'b1, 1'b1, 176, 176, 1'b1, 1'b0, 1'b0));
      add_step(req_row(1'b0, 1'b1));
      // above range clamps to 40
      add_step(csr_row(CSR_VERSION, 8'hFF));
      add_step(typed_row(1'b1, 1'b0, 176, 176, 1'b0, 1'b0, 1'b0));
      // alignment at the corner, clipped by the edge; centre 6 pairs are finder hits
      add_step(csr_row(CSR_VERSION, 7));
      add_step(csr_row(CSR_ALIGN_FIRST, 44));
      add_step(csr_row(CSR_ALIGN_FIRST + 3'd1, 6));
      add_step(typed_row(1'b1, 1'b1, 44, 41, 1'b1, 1'b0, 1'b0));
      add_step(req_row(1'b0, 1'b0));
      add_step(req_row(1'b0, 1'b1));
      // shrink the symbol mid-walk
      add_step(csr_row(CSR_VERSION, 1));
      add_step(req_row(1'b0, 1'b1));
      add_step(req_row(1'b0, 1'b0));
      add_step(csr_row(CSR_ALIGN_FIRST, 0));
      add_step(csr_row(CSR_ALIGN_FIRST + 3'd1, 0));
      add_step(csr_row(CSR_VERSION, 2));
      add_step(csr_row(CSR_ALIGN_FIRST + 3'd2, 18));
      add_step(req_row(1'b1, 1'b1));
      add_step(req_row(1'b0, 1'b0));
      add_step(req_row(1'b0, 1'b1));
      add_step(csr_row(CSR_ALIGN_FIRST + 3'd2, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      in_csr = 0;
      foreach (plan[i]) begin
         s = plan[i];
         if (s.is_csr) begin
            if (!in_csr) settle();
            put_reg(s.addr, s.wdata);
            in_csr = 1;
         end else begin
            if (in_csr) csr_we <= 1'b0;
            in_csr = 0;
            push_request(s.first, s.data, s.typed, s.want);
         end
      end
      if (in_csr) csr_we <= 1'b0;

      for (int ph = 0; ph < 10; ph++) begin
         full = (ph == 1 || ph == 6);
         random_config(full);
         calm = (ph == 3);
         // a phase may carry on the walk left by the previous setting
         f = full || $urandom_range(0, 3) != 0;
         if (full) begin
            push_request(1'b1, 1'($urandom_range(0, 1)), 1'b0, '0);
            while (!wk_done) push_request(1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
            repeat ($urandom_range(1, 4))
               push_request(1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
         end else begin
            n = $urandom_range(10, 35);
            for (k = 0; k < n; k++) begin
               if ((ph == 2 && k == n / 2) || $urandom_range(0, 31) == 0) settle();
               push_request(k == 0 ? f : ($urandom_range(0, 31) == 0),
                            1'($urandom_range(0, 1)), 1'b0, '0);
            end
         end
      end
      calm = 0;

      settle();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
